/* hw/rtl/ldsk_pkg.sv */
// Shared types, constants and rounding helpers for the lidar beam deskew block.
package ldsk_pkg;

    localparam int CMD_W    = 2;
    localparam int POS_W    = 24;
    localparam int YAW_W    = 16;
    localparam int CNT_W    = 13;
    localparam int RNG_W    = 16;
    localparam int ANG_W    = 16;

    localparam int CORDIC_W = 36;
    localparam int ZW       = 33;
    localparam int MUL_W    = 34;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ACC_W    = PROD_W + 1;
    localparam int NUM_W    = 45;
    localparam int MAX_ITERS = 24;
    localparam int IT_W     = $clog2(MAX_ITERS);

    typedef enum logic [CMD_W-1:0] {
        CMD_BASE      = 2'd0,
        CMD_SEG_START = 2'd1,
        CMD_SEG_END   = 2'd2,
        CMD_BEAM      = 2'd3
    } cmd_t;

    localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

    localparam logic [31:0] ATAN_TAB [0:MAX_ITERS-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // right shift, halves rounded away from zero
    function automatic logic signed [CORDIC_W-1:0] shr_rnd(
        input logic signed [CORDIC_W-1:0] v,
        input logic [IT_W-1:0]            s
    );
        logic [CORDIC_W:0] m;
        logic [CORDIC_W:0] h;
        logic [CORDIC_W:0] q;
        m = v[CORDIC_W-1] ? ((CORDIC_W+1)'(0) - {v[CORDIC_W-1], v}) : {1'b0, v};
        h = (s == '0) ? '0 : ((CORDIC_W+1)'(1) << (s - IT_W'(1)));
        q = (m + h) >> s;
        return v[CORDIC_W-1] ? CORDIC_W'((CORDIC_W+1)'(0) - q) : CORDIC_W'(q);
    endfunction

    function automatic logic signed [CORDIC_W-1:0] rnd30(
        input logic signed [ACC_W-1:0] v
    );
        logic [ACC_W-1:0] m;
        logic [ACC_W-1:0] q;
        m = v[ACC_W-1] ? (ACC_W'(0) - v) : v;
        q = (m + (ACC_W'(1) << 29)) >> 30;
        return v[ACC_W-1] ? CORDIC_W'(ACC_W'(0) - q) : CORDIC_W'(q);
    endfunction

endpackage

/* hw/rtl/ldsk_in_if.sv */
// Request channel carrying pose and beam items into the deskew block.
interface ldsk_in_if
    import ldsk_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic signed [POS_W-1:0] pose_x;
    logic signed [POS_W-1:0] pose_y;
    logic signed [YAW_W-1:0] pose_yaw;
    logic [CNT_W-1:0]        beam_count;
    logic [RNG_W-1:0]        range_mm;
    logic signed [ANG_W-1:0] beam_angle;

    modport source (
        output valid, cmd, pose_x, pose_y, pose_yaw, beam_count, range_mm, beam_angle,
        input  ready
    );

    modport sink (
        input  valid, cmd, pose_x, pose_y, pose_yaw, beam_count, range_mm, beam_angle,
        output ready
    );
endinterface

/* hw/rtl/ldsk_out_if.sv */
// Result channel carrying corrected beams out of the deskew block.
interface ldsk_out_if
    import ldsk_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [RNG_W-1:0]        out_range_mm;
    logic signed [ANG_W-1:0] out_angle;
    logic                    segment_last;
    logic                    range_clipped;

    modport source (
        output valid, out_range_mm, out_angle, segment_last, range_clipped,
        input  ready
    );

    modport sink (
        input  valid, out_range_mm, out_angle, segment_last, range_clipped,
        output ready
    );
endinterface

/* hw/rtl/lidar_beam_motion_deskew_top.sv */
// Planar lidar deskew: pose interpolation, shared CORDIC and multiplier under one sequencer.
// Beam request: the time to a result is set by the bit-serial divider and the shared CORDIC (3 passes);
// the next request is taken once the result has been loaded into the output register.
// Zero-range beams skip the arithmetic; pose requests give no result.
// One beam in flight at a time; a finished result may wait while the next request is taken.
// rst_n clears all poses, the beam index and the sequencer; the beam total resets to one.
module lidar_beam_motion_deskew_top
    import ldsk_pkg::*;
#(
    parameter int MAX_SEGMENT_BEAMS = 4096,
    parameter int ANGLE_BITS        = 16
)(
    input  logic        clk,
    input  logic        rst_n,
    ldsk_in_if.sink     in_ch,
    ldsk_out_if.source  out_ch
);

    localparam int ITERS = (ANGLE_BITS < MAX_ITERS) ? ANGLE_BITS : MAX_ITERS;
    localparam int DCNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] MAX_CLIP = (MAX_SEGMENT_BEAMS > (2**CNT_W - 1)) ?
        {CNT_W{1'b1}} : CNT_W'(MAX_SEGMENT_BEAMS);

    typedef enum logic [3:0] {
        S_IDLE, S_IMUL, S_DLOAD, S_DIV, S_IFIN, S_CLOAD, S_CITER, S_CEND,
        S_MMUL, S_MACC, S_DONE
    } state_t;

    typedef enum logic [1:0] {I_YAW, I_X, I_Y} isel_t;
    typedef enum logic [1:0] {P_BASE, P_BEAM, P_VEC} pass_t;
    typedef enum logic [2:0] {
        M_DXBC, M_DYBS, M_RTC, M_DYBC, M_DXBS, M_RTS, M_MAG
    } mstep_t;

    state_t                  state_reg;
    isel_t                   isel_reg;
    pass_t                   pass_reg;
    mstep_t                  mstep_reg;
    logic [DCNT_W-1:0]       dcnt_reg;
    logic [IT_W-1:0]         it_reg;

    logic signed [POS_W-1:0] base_x_reg, base_y_reg;
    logic signed [YAW_W-1:0] base_h_reg;
    logic signed [POS_W-1:0] st_x_reg, st_y_reg;
    logic signed [YAW_W-1:0] st_h_reg;
    logic signed [POS_W-1:0] en_x_reg, en_y_reg;
    logic signed [YAW_W-1:0] en_h_reg;
    logic [CNT_W-1:0]        total_reg;
    logic [CNT_W-1:0]        bidx_reg;

    logic                    out_valid_reg;
    logic [RNG_W-1:0]        out_range_reg;
    logic [ANG_W-1:0]        out_angle_reg;
    logic                    out_last_reg;
    logic                    out_clip_reg;

    logic [CNT_W-1:0]        idx_reg;
    logic                    last_reg;
    logic [RNG_W-1:0]        rng_reg;
    logic [ANG_W-1:0]        bang_reg;
    logic                    neg_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [CNT_W-1:0]        rem_reg;
    logic [31:0]             yaw_reg;
    logic signed [29:0]      dx_reg, dy_reg;
    logic signed [CORDIC_W-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0]    cz_reg;
    logic                    flip_reg;
    logic signed [CORDIC_W-1:0] bc_reg, bs_reg, tc_reg, ts_reg;
    logic signed [CORDIC_W-1:0] vx_reg, vy_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [RNG_W-1:0]        res_range_reg;
    logic [ANG_W-1:0]        res_angle_reg;
    logic                    res_clip_reg;

    logic                    in_fire;
    logic                    out_free;
    logic [CNT_W-1:0]        idx_now;
    logic                    last_now;
    logic [CNT_W-1:0]        seg_n;
    logic signed [YAW_W-1:0] dyaw;
    logic signed [POS_W:0]   dposx, dposy;
    logic [POS_W:0]          dabs;
    logic                    dneg;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic [NUM_W-1:0]        nload;
    logic [CNT_W:0]          rem_w;
    logic                    div_ge;
    logic signed [NUM_W:0]   qs;
    logic [NUM_W:0]          pos_sum;
    logic [31:0]             rot_ang;
    logic [31:0]             rot_ang2;
    logic                    rot_flip;
    logic                    c_up;
    logic signed [CORDIC_W-1:0] sx, sy, nx, ny;
    logic signed [ZW-1:0]    nz;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [CORDIC_W-1:0] vsum;
    logic [PROD_W-1:0]       rfull;
    logic [31:0]             vang_rnd;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;

    assign in_ch.ready          = (state_reg == S_IDLE);
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.out_range_mm  = out_range_reg;
    assign out_ch.out_angle     = out_angle_reg;
    assign out_ch.segment_last  = out_last_reg;
    assign out_ch.range_clipped = out_clip_reg;

    always_comb
    begin
        idx_now  = (bidx_reg < total_reg) ? bidx_reg : '0;
        last_now = (idx_now == total_reg - CNT_W'(1));
        seg_n    = (in_ch.beam_count == '0) ? CNT_W'(1) : in_ch.beam_count;
        if (seg_n > MAX_CLIP)
        begin
            seg_n = MAX_CLIP;
        end
    end

    always_comb
    begin
        dyaw  = en_h_reg - st_h_reg;
        dposx = {en_x_reg[POS_W-1], en_x_reg} - {st_x_reg[POS_W-1], st_x_reg};
        dposy = {en_y_reg[POS_W-1], en_y_reg} - {st_y_reg[POS_W-1], st_y_reg};
        unique case (isel_reg)
            I_YAW:
            begin
                dneg = dyaw[YAW_W-1];
                dabs = dneg ? ((POS_W+1)'(0) - (POS_W+1)'(dyaw)) : (POS_W+1)'(dyaw);
            end
            I_X:
            begin
                dneg = dposx[POS_W];
                dabs = dneg ? ((POS_W+1)'(0) - dposx) : dposx;
            end
            I_Y:
            begin
                dneg = dposy[POS_W];
                dabs = dneg ? ((POS_W+1)'(0) - dposy) : dposy;
            end
            default:
            begin
                dneg = 1'b0;
                dabs = '0;
            end
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_IMUL)
        begin
            mul_a = $signed({{(MUL_W-POS_W-1){1'b0}}, dabs});
            mul_b = $signed({{(MUL_W-CNT_W){1'b0}}, idx_reg});
        end
        else
        begin
            unique case (mstep_reg)
                M_DXBC:
                begin
                    mul_a = MUL_W'(dx_reg);
                    mul_b = MUL_W'(bc_reg);
                end
                M_DYBS:
                begin
                    mul_a = MUL_W'(dy_reg);
                    mul_b = MUL_W'(bs_reg);
                end
                M_RTC:
                begin
                    mul_a = $signed({{(MUL_W-RNG_W-4){1'b0}}, rng_reg, 4'b0});
                    mul_b = MUL_W'(tc_reg);
                end
                M_DYBC:
                begin
                    mul_a = MUL_W'(dy_reg);
                    mul_b = MUL_W'(bc_reg);
                end
                M_DXBS:
                begin
                    mul_a = MUL_W'(dx_reg);
                    mul_b = MUL_W'(bs_reg);
                end
                M_RTS:
                begin
                    mul_a = $signed({{(MUL_W-RNG_W-4){1'b0}}, rng_reg, 4'b0});
                    mul_b = MUL_W'(ts_reg);
                end
                M_MAG:
                begin
                    mul_a = MUL_W'(cx_reg);
                    mul_b = $signed({{(MUL_W-32){1'b0}}, CORDIC_GAIN});
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
        mul_p = mul_a * mul_b;
    end

    always_comb
    begin
        nload = ((isel_reg == I_YAW) ? NUM_W'({prod_reg, 16'b0}) : NUM_W'({prod_reg, 4'b0}))
              + NUM_W'(total_reg[CNT_W-1:1]);
        rem_w  = {rem_reg, num_reg[NUM_W-1]};
        div_ge = (rem_w >= {1'b0, total_reg});
        qs     = neg_reg ? -$signed({1'b0, num_reg}) : $signed({1'b0, num_reg});
        unique case (isel_reg)
            I_Y:
            begin
                pos_sum = {{(NUM_W+1-POS_W-4){st_y_reg[POS_W-1]}}, st_y_reg, 4'b0}
                        + qs
                        - {{(NUM_W+1-POS_W-4){base_y_reg[POS_W-1]}}, base_y_reg, 4'b0};
            end
            default:
            begin
                pos_sum = {{(NUM_W+1-POS_W-4){st_x_reg[POS_W-1]}}, st_x_reg, 4'b0}
                        + qs
                        - {{(NUM_W+1-POS_W-4){base_x_reg[POS_W-1]}}, base_x_reg, 4'b0};
            end
        endcase
    end

    always_comb
    begin
        rot_ang  = (pass_reg == P_BASE) ? {base_h_reg, 16'b0}
                 : (yaw_reg + {bang_reg, 16'b0} - {base_h_reg, 16'b0});
        rot_flip = (rot_ang + 32'h4000_0000) >> 31 != 32'd0;
        rot_ang2 = rot_flip ? (rot_ang + 32'h8000_0000) : rot_ang;

        c_up = (pass_reg == P_VEC) ? !(!cy_reg[CORDIC_W-1] && (cy_reg != '0))
                                   : !cz_reg[ZW-1];
        sx = shr_rnd(cx_reg, it_reg);
        sy = shr_rnd(cy_reg, it_reg);
        nx = c_up ? (cx_reg - sy) : (cx_reg + sy);
        ny = c_up ? (cy_reg + sx) : (cy_reg - sx);
        nz = c_up ? (cz_reg - $signed({1'b0, ATAN_TAB[it_reg]}))
                  : (cz_reg + $signed({1'b0, ATAN_TAB[it_reg]}));

        prod_ext = ACC_W'(prod_reg);
        vsum     = rnd30(acc_reg) + rnd30(prod_ext);
        rfull    = ($unsigned(prod_reg) + (PROD_W'(1) << 33)) >> 34;
        vang_rnd = cz_reg[31:0] + 32'h0000_8000;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            isel_reg      <= I_YAW;
            pass_reg      <= P_BASE;
            mstep_reg     <= M_DXBC;
            dcnt_reg      <= '0;
            it_reg        <= '0;
            base_x_reg    <= '0;
            base_y_reg    <= '0;
            base_h_reg    <= '0;
            st_x_reg      <= '0;
            st_y_reg      <= '0;
            st_h_reg      <= '0;
            en_x_reg      <= '0;
            en_y_reg      <= '0;
            en_h_reg      <= '0;
            total_reg     <= CNT_W'(1);
            bidx_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_range_reg <= '0;
            out_angle_reg <= '0;
            out_last_reg  <= 1'b0;
            out_clip_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        unique case (cmd_t'(in_ch.cmd))
                            CMD_BASE:
                            begin
                                base_x_reg <= in_ch.pose_x;
                                base_y_reg <= in_ch.pose_y;
                                base_h_reg <= in_ch.pose_yaw;
                            end
                            CMD_SEG_START:
                            begin
                                st_x_reg <= in_ch.pose_x;
                                st_y_reg <= in_ch.pose_y;
                                st_h_reg <= in_ch.pose_yaw;
                                bidx_reg <= '0;
                            end
                            CMD_SEG_END:
                            begin
                                en_x_reg  <= in_ch.pose_x;
                                en_y_reg  <= in_ch.pose_y;
                                en_h_reg  <= in_ch.pose_yaw;
                                total_reg <= seg_n;
                                bidx_reg  <= '0;
                            end
                            CMD_BEAM:
                            begin
                                bidx_reg <= last_now ? '0 : (idx_now + CNT_W'(1));
                                isel_reg <= I_YAW;
                                state_reg <= (in_ch.range_mm == '0) ? S_DONE : S_IMUL;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_IMUL:
                begin
                    state_reg <= S_DLOAD;
                end
                S_DLOAD:
                begin
                    dcnt_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    dcnt_reg <= dcnt_reg + DCNT_W'(1);
                    if (dcnt_reg == DCNT_W'(NUM_W - 1))
                    begin
                        state_reg <= S_IFIN;
                    end
                end
                S_IFIN:
                begin
                    unique case (isel_reg)
                        I_YAW:
                        begin
                            isel_reg  <= I_X;
                            state_reg <= S_IMUL;
                        end
                        I_X:
                        begin
                            isel_reg  <= I_Y;
                            state_reg <= S_IMUL;
                        end
                        default:
                        begin
                            pass_reg  <= P_BASE;
                            state_reg <= S_CLOAD;
                        end
                    endcase
                end
                S_CLOAD:
                begin
                    it_reg <= '0;
                    if (pass_reg == P_VEC && vx_reg == '0 && vy_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_CITER;
                    end
                end
                S_CITER:
                begin
                    it_reg <= it_reg + IT_W'(1);
                    if (it_reg == IT_W'(ITERS - 1))
                    begin
                        state_reg <= S_CEND;
                    end
                end
                S_CEND:
                begin
                    unique case (pass_reg)
                        P_BASE:
                        begin
                            pass_reg  <= P_BEAM;
                            state_reg <= S_CLOAD;
                        end
                        P_BEAM:
                        begin
                            mstep_reg <= M_DXBC;
                            state_reg <= S_MMUL;
                        end
                        default:
                        begin
                            mstep_reg <= M_MAG;
                            state_reg <= S_MMUL;
                        end
                    endcase
                end
                S_MMUL:
                begin
                    state_reg <= S_MACC;
                end
                S_MACC:
                begin
                    unique case (mstep_reg)
                        M_DXBC:
                        begin
                            mstep_reg <= M_DYBS;
                            state_reg <= S_MMUL;
                        end
                        M_DYBS:
                        begin
                            mstep_reg <= M_RTC;
                            state_reg <= S_MMUL;
                        end
                        M_RTC:
                        begin
                            mstep_reg <= M_DYBC;
                            state_reg <= S_MMUL;
                        end
                        M_DYBC:
                        begin
                            mstep_reg <= M_DXBS;
                            state_reg <= S_MMUL;
                        end
                        M_DXBS:
                        begin
                            mstep_reg <= M_RTS;
                            state_reg <= S_MMUL;
                        end
                        M_RTS:
                        begin
                            pass_reg  <= P_VEC;
                            state_reg <= S_CLOAD;
                        end
                        default:
                        begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_range_reg <= res_range_reg;
                        out_angle_reg <= res_angle_reg;
                        out_last_reg  <= last_reg;
                        out_clip_reg  <= res_clip_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && in_ch.cmd == CMD_BEAM)
                begin
                    idx_reg       <= idx_now;
                    last_reg      <= last_now;
                    rng_reg       <= in_ch.range_mm;
                    bang_reg      <= in_ch.beam_angle;
                    res_range_reg <= '0;
                    res_angle_reg <= in_ch.beam_angle;
                    res_clip_reg  <= 1'b0;
                end
            end
            S_IMUL:
            begin
                prod_reg <= mul_p;
                neg_reg  <= dneg;
            end
            S_DLOAD:
            begin
                num_reg <= nload;
                rem_reg <= '0;
            end
            S_DIV:
            begin
                num_reg <= {num_reg[NUM_W-2:0], div_ge};
                rem_reg <= div_ge ? CNT_W'(rem_w - {1'b0, total_reg}) : CNT_W'(rem_w);
            end
            S_IFIN:
            begin
                unique case (isel_reg)
                    I_YAW:
                    begin
                        yaw_reg <= {st_h_reg, 16'b0} + qs[31:0];
                    end
                    I_X:
                    begin
                        dx_reg <= 30'(pos_sum);
                    end
                    default:
                    begin
                        dy_reg <= 30'(pos_sum);
                    end
                endcase
            end
            S_CLOAD:
            begin
                if (pass_reg == P_VEC)
                begin
                    if (vx_reg == '0 && vy_reg == '0)
                    begin
                        res_range_reg <= '0;
                        res_angle_reg <= '0;
                        res_clip_reg  <= 1'b0;
                    end
                    else if (vx_reg[CORDIC_W-1])
                    begin
                        cx_reg <= -vx_reg;
                        cy_reg <= -vy_reg;
                        cz_reg <= $signed({1'b0, 32'h8000_0000});
                    end
                    else
                    begin
                        cx_reg <= vx_reg;
                        cy_reg <= vy_reg;
                        cz_reg <= '0;
                    end
                end
                else
                begin
                    cx_reg   <= $signed({{(CORDIC_W-32){1'b0}}, CORDIC_GAIN});
                    cy_reg   <= '0;
                    cz_reg   <= $signed({rot_ang2[31], rot_ang2});
                    flip_reg <= rot_flip;
                end
            end
            S_CITER:
            begin
                cx_reg <= nx;
                cy_reg <= ny;
                cz_reg <= nz;
            end
            S_CEND:
            begin
                unique case (pass_reg)
                    P_BASE:
                    begin
                        bc_reg <= flip_reg ? -cx_reg : cx_reg;
                        bs_reg <= flip_reg ? -cy_reg : cy_reg;
                    end
                    P_BEAM:
                    begin
                        tc_reg <= flip_reg ? -cx_reg : cx_reg;
                        ts_reg <= flip_reg ? -cy_reg : cy_reg;
                    end
                    default:
                    begin
                        res_angle_reg <= vang_rnd[31:16];
                    end
                endcase
            end
            S_MMUL:
            begin
                prod_reg <= mul_p;
            end
            S_MACC:
            begin
                unique case (mstep_reg)
                    M_DXBC, M_DYBC:
                    begin
                        acc_reg <= prod_ext;
                    end
                    M_DYBS:
                    begin
                        acc_reg <= acc_reg + prod_ext;
                    end
                    M_DXBS:
                    begin
                        acc_reg <= acc_reg - prod_ext;
                    end
                    M_RTC:
                    begin
                        vx_reg <= vsum;
                    end
                    M_RTS:
                    begin
                        vy_reg <= vsum;
                    end
                    default:
                    begin
                        if (rfull > PROD_W'(16'hFFFF))
                        begin
                            res_range_reg <= '1;
                            res_clip_reg  <= 1'b1;
                        end
                        else
                        begin
                            res_range_reg <= rfull[RNG_W-1:0];
                            res_clip_reg  <= 1'b0;
                        end
                    end
                endcase
            end
            default:
            begin
                res_clip_reg <= res_clip_reg;
            end
        endcase
    end

    a_busy_after_beam: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.cmd == CMD_BEAM) |=> !in_ch.ready)
        else $error("request taken while a beam is in work");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        bidx_reg < total_reg)
        else $error("beam index outside its segment");

    a_total_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg != '0) && (total_reg <= MAX_CLIP))
        else $error("segment beam total out of bounds");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the completion step");

endmodule
